### rtl/sensor_sentence_field_parser_defines.svh
// ----------------------------------------------------------------------------
// Sensor sentence field parser: assertion macros
// Shorthand for the concurrent checks in the parser's controller RTL.
// ----------------------------------------------------------------------------
`ifndef SENSOR_SENTENCE_FIELD_PARSER_DEFINES_SVH
`define SENSOR_SENTENCE_FIELD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSFP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ssfp_pkg.sv
// ----------------------------------------------------------------------------
// ssfp_pkg
// Constants and shared types of the sensor sentence field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ssfp_pkg;

  // Field capacities in characters.
  localparam int ACCEL_FIELD_CHARS  = 6;
  localparam int MAGNET_FIELD_CHARS = 4;

  localparam int MAX_FIELD_CHARS = (ACCEL_FIELD_CHARS > MAGNET_FIELD_CHARS) ?
                                   ACCEL_FIELD_CHARS : MAGNET_FIELD_CHARS;
  localparam int POS_W       = $clog2(MAX_FIELD_CHARS + 1);
  localparam int STORE_DEPTH = 3 * ACCEL_FIELD_CHARS + 3 * MAGNET_FIELD_CHARS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam int ACC_W   = 21;
  localparam int MAG_W   = 15;
  localparam int VAL_W   = ACC_W;
  localparam int COMMA_W = 5;
  localparam int FIELD_W = 3;

  localparam logic [COMMA_W-1:0] PARKED_COMMAS = 5'd25;
  localparam logic [COMMA_W-1:0] MAX_COMMAS    = 5'd31;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_E       = 8'h45;
  localparam logic [7:0] CH_O       = 8'h4F;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_OK      = 2'd1,
    KIND_ERR     = 2'd2,
    KIND_RAW     = 2'd3
  } kind_t;

  typedef struct packed {
    logic parse;       // update parser state from the accepted word
    logic walk_start;  // newline accepted: restart the conversion walk
    logic walk;        // conversion walk in progress
    logic publish;     // move results to the output and close the sentence
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_newline;  // current word is an error-free newline
    logic walk_done;   // last stored character has been converted
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/ssfp_ram.sv
// ----------------------------------------------------------------------------
// ssfp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/ssfp_ctrl.sv
// ----------------------------------------------------------------------------
// ssfp_ctrl
// Controller: handshakes, sentence-end conversion sequencing, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensor_sentence_field_parser_defines.svh"

module ssfp_ctrl
  import ssfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_WALK    = 3'b010,
    ST_PUBLISH = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.parse      = accept && !status.is_newline;
    cmd.walk_start = accept && status.is_newline;
    cmd.walk       = (state == ST_WALK);
    cmd.publish    = (state == ST_PUBLISH) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.walk_start) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.walk_done) begin
          state_next = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (cmd.publish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A new result may replace the old one in the cycle the old one is taken.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `SSFP_ASSERT_SAME(a_done_in_walk, clk, rst, status.walk_done, state == ST_WALK, "walk_done outside of the conversion walk")
  `SSFP_ASSERT_NEXT(a_newline_walks, clk, rst, accept && status.is_newline, state == ST_WALK, "newline did not start a conversion")
  `SSFP_ASSERT_NEXT(a_hold_pending, clk, rst, (state == ST_PUBLISH) && out_valid && !out_ready, state == ST_PUBLISH, "result published over a pending word")
  `SSFP_ASSERT_SAME(a_rise_from_publish, clk, rst, $rose(out_valid), $past(state == ST_PUBLISH), "output valid rose without a publish")

endmodule

`default_nettype wire

### rtl/ssfp_datapath.sv
// ----------------------------------------------------------------------------
// ssfp_datapath
// Datapath: sentence parser state, field character store, and a one
// character per cycle decimal converter for the six fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ssfp_datapath
  import ssfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              rx_error,
  input  wire ctrl_cmd_t         cmd,
  output dp_status_t             status,
  output logic signed [ACC_W-1:0] acc_x,
  output logic signed [ACC_W-1:0] acc_y,
  output logic signed [ACC_W-1:0] acc_z,
  output logic signed [MAG_W-1:0] mag_x,
  output logic signed [MAG_W-1:0] mag_y,
  output logic signed [MAG_W-1:0] mag_z
);

  typedef enum logic [2:0] {
    CONV_SKIP   = 3'b001,
    CONV_DIGITS = 3'b010,
    CONV_STOP   = 3'b100
  } conv_phase_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Fields are stored back to back: three accelerometer fields, then three
  // magnetometer fields.
  function automatic logic [STORE_AW-1:0] field_base(input logic [FIELD_W-1:0] f);
    logic [STORE_AW-1:0] b;
    if (f < FIELD_W'(3)) begin
      b = STORE_AW'(int'(f) * ACCEL_FIELD_CHARS);
    end else begin
      b = STORE_AW'(3 * ACCEL_FIELD_CHARS + (int'(f) - 3) * MAGNET_FIELD_CHARS);
    end
    return b;
  endfunction

  // ---------------------------------------------------------------- parser
  logic [COMMA_W-1:0]  comma_count, comma_count_next;
  kind_t               sentence_kind, sentence_kind_next;
  logic [POS_W-1:0]    char_position, char_position_next;
  logic [STORE_DEPTH-1:0] entry_valid;
  logic                st_we;
  logic [STORE_AW-1:0] st_waddr;
  logic [FIELD_W-1:0]  wr_field;

  assign wr_field = comma_count[FIELD_W-1:0] - FIELD_W'(1);
  assign status.is_newline = (rx_byte == CH_NEWLINE) && !rx_error;

  always_comb begin
    comma_count_next   = comma_count;
    sentence_kind_next = sentence_kind;
    char_position_next = char_position;
    st_we              = 1'b0;
    st_waddr           = field_base(wr_field) + STORE_AW'(char_position);
    if (cmd.parse && !rx_error) begin
      if (rx_byte == CH_NUL) begin
        comma_count_next   = PARKED_COMMAS;
        sentence_kind_next = KIND_UNKNOWN;
      end else if (rx_byte == CH_DOLLAR) begin
        comma_count_next   = '0;
        sentence_kind_next = KIND_UNKNOWN;
      end else if (rx_byte == CH_COMMA) begin
        if (comma_count < MAX_COMMAS) begin
          comma_count_next = comma_count + COMMA_W'(1);
        end
        char_position_next = '0;
      end else if (comma_count == '0) begin
        if (rx_byte == CH_E) begin
          sentence_kind_next = KIND_ERR;
        end else if (rx_byte == CH_O) begin
          sentence_kind_next = KIND_OK;
        end else if (rx_byte == CH_R) begin
          sentence_kind_next = KIND_RAW;
        end
      end else if (sentence_kind == KIND_RAW) begin
        if ((comma_count <= COMMA_W'(3)) &&
            (char_position < POS_W'(ACCEL_FIELD_CHARS))) begin
          st_we              = 1'b1;
          char_position_next = char_position + POS_W'(1);
        end else if ((comma_count >= COMMA_W'(4)) && (comma_count <= COMMA_W'(6)) &&
                     (char_position < POS_W'(MAGNET_FIELD_CHARS))) begin
          st_we              = 1'b1;
          char_position_next = char_position + POS_W'(1);
        end
      end
    end
    if (cmd.publish) begin
      comma_count_next   = PARKED_COMMAS;
      sentence_kind_next = KIND_UNKNOWN;
    end
  end

  // Entries not written since the last sentence end read as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      comma_count   <= PARKED_COMMAS;
      sentence_kind <= KIND_UNKNOWN;
      char_position <= '0;
      entry_valid   <= '0;
    end else begin
      comma_count   <= comma_count_next;
      sentence_kind <= sentence_kind_next;
      char_position <= char_position_next;
      if (cmd.publish) begin
        entry_valid <= '0;
      end else if (st_we) begin
        entry_valid[st_waddr] <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------ char store
  logic [STORE_AW:0]   iss_cnt;
  logic                iss_valid;
  logic [STORE_AW-1:0] raddr;
  logic [7:0]          rd_data;
  logic                q_valid;
  logic                q_entry_valid;

  assign iss_valid = cmd.walk && (iss_cnt < (STORE_AW + 1)'(STORE_DEPTH));
  assign raddr     = iss_cnt[STORE_AW-1:0];

  ssfp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (rx_byte),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_cnt <= '0;
      q_valid <= 1'b0;
    end else begin
      if (cmd.walk_start) begin
        iss_cnt <= '0;
      end else if (iss_valid) begin
        iss_cnt <= iss_cnt + (STORE_AW + 1)'(1);
      end
      q_valid <= iss_valid;
    end
  end

  always_ff @(posedge clk) begin
    q_entry_valid <= iss_valid && entry_valid[raddr];
  end

  // ------------------------------------------------------------ converter
  logic [FIELD_W-1:0] proc_field;
  logic [POS_W-1:0]   proc_pos;
  logic [POS_W-1:0]   last_pos;
  logic               last_char;
  conv_phase_t        conv_phase, phase_upd;
  logic               conv_neg, neg_upd;
  logic [VAL_W-1:0]   conv_val, val_upd, val_tens, final_val;
  logic [VAL_W-1:0]   digit;
  logic [7:0]         ch;
  logic [VAL_W-1:0]   res [6];

  assign ch        = q_entry_valid ? rd_data : CH_NUL;
  assign digit     = VAL_W'(ch[3:0]);
  assign val_tens  = (conv_val << 3) + (conv_val << 1);
  assign last_pos  = (proc_field < FIELD_W'(3)) ? POS_W'(ACCEL_FIELD_CHARS - 1) :
                                                  POS_W'(MAGNET_FIELD_CHARS - 1);
  assign last_char = (proc_pos == last_pos);

  always_comb begin
    phase_upd = conv_phase;
    neg_upd   = conv_neg;
    val_upd   = conv_val;
    unique case (conv_phase)
      CONV_SKIP: begin
        if (is_space(ch)) begin
          phase_upd = CONV_SKIP;
        end else if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
          neg_upd   = (ch == CH_MINUS);
          phase_upd = CONV_DIGITS;
        end else if (is_digit(ch)) begin
          val_upd   = digit;
          phase_upd = CONV_DIGITS;
        end else begin
          phase_upd = CONV_STOP;
        end
      end
      CONV_DIGITS: begin
        if (is_digit(ch)) begin
          val_upd = val_tens + digit;
        end else begin
          phase_upd = CONV_STOP;
        end
      end
      CONV_STOP: phase_upd = CONV_STOP;
      default:   phase_upd = CONV_STOP;
    endcase
  end

  assign final_val        = neg_upd ? (VAL_W'(0) - val_upd) : val_upd;
  assign status.walk_done = q_valid && last_char && (proc_field == FIELD_W'(5));

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_field <= '0;
      proc_pos   <= '0;
      conv_phase <= CONV_SKIP;
      conv_neg   <= 1'b0;
      conv_val   <= '0;
    end else if (cmd.walk_start) begin
      proc_field <= '0;
      proc_pos   <= '0;
      conv_phase <= CONV_SKIP;
      conv_neg   <= 1'b0;
      conv_val   <= '0;
    end else if (q_valid) begin
      if (last_char) begin
        proc_field <= proc_field + FIELD_W'(1);
        proc_pos   <= '0;
        conv_phase <= CONV_SKIP;
        conv_neg   <= 1'b0;
        conv_val   <= '0;
      end else begin
        proc_pos   <= proc_pos + POS_W'(1);
        conv_phase <= phase_upd;
        conv_neg   <= neg_upd;
        conv_val   <= val_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && last_char) begin
      res[proc_field] <= final_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      acc_x <= res[0];
      acc_y <= res[1];
      acc_z <= res[2];
      mag_x <= res[3][MAG_W-1:0];
      mag_y <= res[4][MAG_W-1:0];
      mag_z <= res[5][MAG_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/sensor_sentence_field_parser.sv
// ----------------------------------------------------------------------------
// sensor_sentence_field_parser
// Parses a serial text stream of sensor sentences and, at each newline,
// returns the six raw sensor fields as signed decimal integers.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_ready   rx_byte[7:0], rx_error
//   output   out        out_valid / out_ready acc_x/y/z[20:0], mag_x/y/z[14:0]
//
// An ordinary word is accepted while the block is idle. A newline starts a
// walk over the field store, one stored character per cycle from a
// registered RAM read: the result is offered once the last stored character
// has been converted, and no word is taken during the walk. Words are still
// taken while a result waits at the output; a finished conversion waits
// there until the slot frees.
// Reset is synchronous and leaves the store empty with no sentence open.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_sentence_field_parser
  import ssfp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                rx_error,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [ACC_W-1:0]  acc_x,
  output logic signed [ACC_W-1:0]  acc_y,
  output logic signed [ACC_W-1:0]  acc_z,
  output logic signed [MAG_W-1:0]  mag_x,
  output logic signed [MAG_W-1:0]  mag_y,
  output logic signed [MAG_W-1:0]  mag_z
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ssfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ssfp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (rx_byte),
    .rx_error (rx_error),
    .cmd      (cmd),
    .status   (status),
    .acc_x    (acc_x),
    .acc_y    (acc_y),
    .acc_z    (acc_z),
    .mag_x    (mag_x),
    .mag_y    (mag_y),
    .mag_z    (mag_z)
  );

endmodule

`default_nettype wire
